// ===== design/imhq_pkg.sv =====
`timescale 1ns / 1ps
package imhq_pkg;
   localparam int Capacity     = 64;
   localparam int SlotBits     = $clog2(Capacity);
   localparam int CountBits    = 7;
   localparam int JobIds       = 64;
   localparam int JobBits      = 6;
   localparam int PriorityBits = 16;
   localparam int KeyWidth     = 16;
   localparam int EntryBits    = JobBits + PriorityBits;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_TOP    = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_FULL       = 3'd2,
      ST_DUPLICATE  = 3'd3,
      ST_NOT_QUEUED = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [JobBits-1:0]  job_id;
      logic [KeyWidth-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [JobBits-1:0]   out_job;
      logic [KeyWidth-1:0]  out_priority;
      logic [CountBits-1:0] count;
   } rsp_type;
endpackage

// ===== design/imhq_if.sv =====
`timescale 1ns / 1ps
interface imhq_req_if;
   logic             valid;
   logic             ready;
   imhq_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface imhq_rsp_if;
   logic             valid;
   logic             ready;
   imhq_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/imhq_ram.sv =====
`timescale 1ns / 1ps
module imhq_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/indexed_max_heap_queue.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Fields
// req     | in  | func, job_id, priority_req
// rsp     | out | status, out_job, out_priority, count
//
// One item at a time. A status-only result goes through S_DECODE and S_DONE into
// the output register. Through the single-read-port slot RAM each level of a sift
// takes S_PLACE, S_UPRD, S_UPCMP upwards and S_PLACE, S_DNRDL, S_DNRDR, S_DNCMP
// downwards; the worst case is a pop or root removal that sinks five levels.
// Synchronous reset clears the count, the queued bits, the FSM and the result valid flag.
// The result is held in an output register until transferred; a new item is
// accepted once that register is free.
module indexed_max_heap_queue (
   input  logic clock,
   input  logic reset,
   imhq_req_if.sink   req,
   imhq_rsp_if.source rsp
);
   localparam int SB = imhq_pkg::SlotBits;
   localparam int JB = imhq_pkg::JobBits;
   localparam int KB = imhq_pkg::KeyWidth;
   localparam int CB = imhq_pkg::CountBits;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_LDLAST = 10'b0000000100,
      S_PLACE  = 10'b0000001000,
      S_UPRD   = 10'b0000010000,
      S_UPCMP  = 10'b0000100000,
      S_DNRDL  = 10'b0001000000,
      S_DNRDR  = 10'b0010000000,
      S_DNCMP  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  func_ff, func_in;
   logic [JB-1:0] job_ff, job_in;
   logic [KB-1:0] key_ff, key_in;
   logic [SB-1:0] cur_ff, cur_in;        // slot of the moving entry
   logic [JB-1:0] mjob_ff, mjob_in;      // moving entry
   logic [KB-1:0] mkey_ff, mkey_in;
   logic [JB-1:0] cjob_ff, cjob_in;      // best child
   logic [KB-1:0] ckey_ff, ckey_in;
   logic [SB-1:0] cslot_ff, cslot_in;
   logic          up_ff, up_in;          // sift-up phase also wanted
   logic          dn_ff, dn_in;          // sift-down phase wanted
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [imhq_pkg::JobIds-1:0] queued_ff, queued_in;
   logic          rsp_valid_ff, rsp_valid_in;
   imhq_pkg::rsp_type rsp_ff, rsp_in;

   // slot RAM: {job, key}
   logic          h_we;
   logic [SB-1:0] h_wa, h_ra;
   logic [imhq_pkg::EntryBits-1:0] h_wd, h_rd;
   // position RAM: job -> slot
   logic          p_we;
   logic [JB-1:0] p_wa, p_ra;
   logic [SB-1:0] p_wd, p_rd;

   imhq_ram #(.Width(imhq_pkg::EntryBits), .Depth(imhq_pkg::Capacity)) u_heap (
      .clock, .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));
   imhq_ram #(.Width(SB), .Depth(imhq_pkg::JobIds)) u_pos (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   logic [JB-1:0] rd_job;
   logic [KB-1:0] rd_key;
   assign rd_job = h_rd[imhq_pkg::EntryBits-1:KB];
   assign rd_key = h_rd[KB-1:0];

   logic [SB-1:0] parent, left, right;
   logic [CB:0]   left_w;
   logic [CB-1:0] last;
   assign parent = (cur_ff - SB'(1)) >> 1;
   assign left_w = {1'b0, cur_ff, 1'b1};
   assign left   = left_w[SB-1:0];
   assign right  = left + SB'(1);
   assign last   = cnt_ff - CB'(1);

   assign req.ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff; func_in = func_ff; job_in = job_ff; key_in = key_ff;
      cur_in = cur_ff; mjob_in = mjob_ff; mkey_in = mkey_ff;
      cjob_in = cjob_ff; ckey_in = ckey_ff; cslot_in = cslot_ff;
      up_in = up_ff; dn_in = dn_ff; cnt_in = cnt_ff; queued_in = queued_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      h_we = 1'b0; h_wa = cur_ff; h_wd = {mjob_ff, mkey_ff}; h_ra = '0;
      p_we = 1'b0; p_wa = mjob_ff; p_wd = cur_ff; p_ra = job_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         // capture the request; read root and position
         S_IDLE: begin
            p_ra = req.payload.job_id;
            h_ra = '0;
            if (req.valid && req.ready) begin
               func_in = req.payload.func;
               job_in  = req.payload.job_id;
               key_in  = req.payload.priority_req;
               rsp_in  = '0;
               state_in = S_DECODE;
            end
         end
         // check status; pick target slot
         S_DECODE: begin
            rsp_in.status = imhq_pkg::ST_OK;
            state_in = S_DONE;
            case (func_ff)
               imhq_pkg::FUNC_PUSH: begin
                  if (queued_ff[job_ff]) rsp_in.status = imhq_pkg::ST_DUPLICATE;
                  else if (cnt_ff >= CB'(imhq_pkg::Capacity))
                     rsp_in.status = imhq_pkg::ST_FULL;
                  else begin
                     queued_in[job_ff] = 1'b1;
                     cur_in = cnt_ff[SB-1:0];
                     cnt_in = cnt_ff + CB'(1);
                     mjob_in = job_ff; mkey_in = key_ff;
                     up_in = 1'b1; dn_in = 1'b0;
                     state_in = S_PLACE;
                  end
               end
               imhq_pkg::FUNC_POP, imhq_pkg::FUNC_TOP: begin
                  if (cnt_ff == '0) rsp_in.status = imhq_pkg::ST_EMPTY;
                  else begin
                     rsp_in.out_job = rd_job; rsp_in.out_priority = rd_key;
                     if (func_ff == imhq_pkg::FUNC_POP) begin
                        queued_in[rd_job] = 1'b0;
                        cnt_in = last; cur_in = '0;
                        up_in = 1'b0; dn_in = 1'b1;
                        h_ra = last[SB-1:0];
                        state_in = (last == '0) ? S_DONE : S_LDLAST;
                     end
                  end
               end
               default: begin
                  if (!queued_ff[job_ff] || {1'b0, p_rd} >= cnt_ff)
                     rsp_in.status = imhq_pkg::ST_NOT_QUEUED;
                  else begin
                     // slot read follows; the key comes from it, the job from the request
                     queued_in[job_ff] = 1'b0;
                     cnt_in = last; cur_in = p_rd;
                     rsp_in.out_job = job_ff;
                     up_in = 1'b1; dn_in = 1'b1;
                     h_ra = last[SB-1:0];
                     state_in = ({1'b0, p_rd} >= last) ? S_DONE : S_LDLAST;
                     // key of removed entry fetched in S_LDLAST via extra read
                     func_in = imhq_pkg::FUNC_REMOVE;
                  end
               end
            endcase
            if (func_ff == imhq_pkg::FUNC_REMOVE && state_in == S_DONE &&
                rsp_in.status == imhq_pkg::ST_OK) begin
               h_ra = p_rd; state_in = S_LDLAST; dn_in = 1'b0; up_in = 1'b0;
            end
         end
         // last entry (or removed key) is on the read port
         S_LDLAST: begin
            if (func_ff == imhq_pkg::FUNC_REMOVE && rsp_ff.out_priority == '0 &&
                !up_ff && !dn_ff) begin
               // removal of the last slot: only the key is needed
               rsp_in.out_priority = rd_key;
               state_in = S_DONE;
            end else begin
               mjob_in = rd_job; mkey_in = rd_key;
               h_ra = cur_ff;
               state_in = S_PLACE;
            end
         end
         // write moving entry at cur, read next neighbour
         S_PLACE: begin
            // removed entry is on the read port only at the first placement
            if (func_ff == imhq_pkg::FUNC_REMOVE && up_ff && dn_ff)
               rsp_in.out_priority = rd_key;
            h_we = 1'b1; p_we = 1'b1;
            h_ra = parent;
            if (up_ff && cur_ff != '0) state_in = S_UPRD;
            else if (dn_ff) begin
               up_in = 1'b0; state_in = S_DNRDL;
            end else state_in = S_DONE;
         end
         S_UPRD: begin
            h_ra = parent; state_in = S_UPCMP;
         end
         // move parent down if moving key is strictly larger
         S_UPCMP: begin
            if (mkey_ff > rd_key) begin
               h_we = 1'b1; h_wa = cur_ff; h_wd = h_rd;
               p_we = 1'b1; p_wa = rd_job; p_wd = cur_ff;
               cur_in = parent; dn_in = 1'b0;
               state_in = S_PLACE;
            end else begin
               up_in = 1'b0;
               state_in = dn_ff ? S_DNRDL : S_DONE;
            end
         end
         S_DNRDL: begin
            h_ra = left;
            if (left_w >= {1'b0, cnt_ff}) state_in = S_DONE;
            else state_in = S_DNRDR;
         end
         S_DNRDR: begin
            cjob_in = rd_job; ckey_in = rd_key; cslot_in = left;
            if ({1'b0, right} < cnt_ff && left != '1) begin
               h_ra = right; state_in = S_DNCMP; dn_in = 1'b1;
            end else begin
               state_in = S_DNCMP; dn_in = 1'b0;
            end
         end
         // choose child and swap down if strictly larger
         S_DNCMP: begin
            logic [JB-1:0] bj;
            logic [KB-1:0] bk;
            logic [SB-1:0] bs;
            bj = cjob_ff; bk = ckey_ff; bs = cslot_ff;
            if (dn_ff && rd_key > ckey_ff) begin
               bj = rd_job; bk = rd_key; bs = cslot_ff + SB'(1);
            end
            dn_in = 1'b1;
            if (bk > mkey_ff) begin
               h_we = 1'b1; h_wa = cur_ff; h_wd = {bj, bk};
               p_we = 1'b1; p_wa = bj; p_wd = cur_ff;
               cur_in = bs; up_in = 1'b0;
               state_in = S_PLACE;
            end else state_in = S_DONE;
         end
         S_DONE: begin
            rsp_in.count = cnt_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; queued_ff <= '0;
         rsp_valid_ff <= 1'b0; up_ff <= 1'b0; dn_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; queued_ff <= queued_in;
         rsp_valid_ff <= rsp_valid_in; up_ff <= up_in; dn_ff <= dn_in;
      end
      func_ff <= func_in; job_ff <= job_in; key_ff <= key_in;
      cur_ff <= cur_in; mjob_ff <= mjob_in; mkey_ff <= mkey_in;
      cjob_ff <= cjob_in; ckey_ff <= ckey_in; cslot_ff <= cslot_in;
      rsp_ff <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(imhq_pkg::Capacity)) else $error("count overflow");
   a_count_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(queued_ff) == int'(cnt_ff))
      else $error("queued bits disagree with count");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result dropped");
endmodule
